// ----- src/stq_pkg.sv -----
package stq_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TOUT_W  = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned RCNT_W  = 6;
  localparam int unsigned TIME_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 2'd0,
    CMD_DEL_KEY   = 2'd1,
    CMD_DEL_OWNER = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_DELETED = 3'd2,
    KIND_EXPIRED = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

endpackage

// ----- src/stq_in_if.sv -----
interface stq_in_if;
  logic                         valid;
  logic                         ready;
  logic [stq_pkg::CMD_W-1:0]    cmd;
  logic [stq_pkg::OWNER_W-1:0]  owner_id;
  logic [stq_pkg::KEY_W-1:0]    key_tag;
  logic [stq_pkg::TOUT_W-1:0]   timeout_secs;

  modport source (output valid, cmd, owner_id, key_tag, timeout_secs, input ready);
  modport sink (input valid, cmd, owner_id, key_tag, timeout_secs, output ready);
endinterface

// ----- src/stq_out_if.sv -----
interface stq_out_if;
  logic                         valid;
  logic                         ready;
  logic [stq_pkg::KIND_W-1:0]   kind;
  logic [stq_pkg::OWNER_W-1:0]  owner_id_out;
  logic [stq_pkg::KEY_W-1:0]    key_tag_out;
  logic [stq_pkg::RCNT_W-1:0]   removed_count;
  logic                         last;

  modport source (output valid, kind, owner_id_out, key_tag_out, removed_count, last,
                  input ready);
  modport sink (input valid, kind, owner_id_out, key_tag_out, removed_count, last,
                output ready);
endinterface

// ----- src/sorted_timeout_queue_unit.sv -----
// Sorted timeout queue: a table of up to DEPTH pending timeouts held in
// ascending order of expiry second in one synchronous memory.
// in_ch carries one command per transaction: add, delete by owner and key,
// delete by owner, or a one-second tick. out_ch returns the results of that
// command; the last one carries last = 1. A tick returns one transaction per
// expired entry, in expiry order, then a done marker.
// One command is handled at a time; in_ch.ready is high only when idle.
// An add reads, compares and shifts each entry that expires later than the
// new one up one place, from the top down, then writes the new entry.
// A delete streams the entries through the read port, one entry per cycle,
// and writes the survivors back down. A tick returns the expired entries
// from the bottom, then closes up any survivors in the same way.
// Results leave through one output register; a stall on out_ch holds the
// sequencer until the register empties.
// Reset (rst_n low at a clock edge) empties the table and zeroes the second
// counter at once; no clearing pass is needed.
module sorted_timeout_queue_unit #(
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  stq_in_if.sink           in_ch,
  stq_out_if.source        out_ch
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = stq_pkg::TIME_W;
  localparam int unsigned OW = stq_pkg::OWNER_W;
  localparam int unsigned EW = TW + OW + KEY_BITS;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ADD_RD = 7'b0000010,
    ST_ADD_WR = 7'b0000100,
    ST_RUN    = 7'b0001000,
    ST_TK_RD  = 7'b0010000,
    ST_TK_CHK = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [TW-1:0]               now_r, now_nxt;
  logic [CW-1:0]               i_r, i_nxt;
  logic [CW-1:0]               w_r, w_nxt;
  logic                        pv_r, pv_nxt;
  logic [stq_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [OW-1:0]               own_r, own_nxt;
  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [TW-1:0]               exp_r, exp_nxt;
  logic [stq_pkg::KIND_W-1:0]  rkind_r, rkind_nxt;
  logic [stq_pkg::RCNT_W-1:0]  rcnt_r, rcnt_nxt;

  logic                        ov_r, ov_nxt;
  logic [stq_pkg::KIND_W-1:0]  okind_r, okind_nxt;
  logic [OW-1:0]               oown_r, oown_nxt;
  logic [stq_pkg::KEY_W-1:0]   okey_r, okey_nxt;
  logic [stq_pkg::RCNT_W-1:0]  orcnt_r, orcnt_nxt;
  logic                        olast_r, olast_nxt;

  logic [EW-1:0]               mem [DEPTH];
  logic [EW-1:0]               rd_q;
  logic                        we;
  logic [CW-1:0]               waddr;
  logic [EW-1:0]               wdata;
  logic [CW-1:0]               raddr;

  logic [TW-1:0]               rd_exp;
  logic [OW-1:0]               rd_own;
  logic [KEY_BITS-1:0]         rd_key;
  logic                        slot_free;
  logic                        hit;
  logic                        in_acc;

  assign rd_exp    = rd_q[EW-1 -: TW];
  assign rd_own    = rd_q[KEY_BITS +: OW];
  assign rd_key    = rd_q[KEY_BITS-1:0];
  assign slot_free = !ov_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign hit       = (cmd_r != stq_pkg::CMD_TICK) && (rd_own == own_r) &&
                     ((cmd_r == stq_pkg::CMD_DEL_OWNER) || (rd_key == key_r));

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = okind_r;
  assign out_ch.owner_id_out  = oown_r;
  assign out_ch.key_tag_out   = okey_r;
  assign out_ch.removed_count = orcnt_r;
  assign out_ch.last          = olast_r;

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rd_q <= mem[raddr[AW-1:0]];
  end

  // Sequence the command over the memory
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    now_nxt   = now_r;
    i_nxt     = i_r;
    w_nxt     = w_r;
    pv_nxt    = 1'b0;
    cmd_nxt   = cmd_r;
    own_nxt   = own_r;
    key_nxt   = key_r;
    exp_nxt   = exp_r;
    rkind_nxt = rkind_r;
    rcnt_nxt  = rcnt_r;
    ov_nxt    = ov_r && !out_ch.ready;
    okind_nxt = okind_r;
    oown_nxt  = oown_r;
    okey_nxt  = okey_r;
    orcnt_nxt = orcnt_r;
    olast_nxt = olast_r;
    we        = 1'b0;
    waddr     = w_r;
    wdata     = rd_q;
    raddr     = i_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_ch.cmd;
          own_nxt   = in_ch.owner_id;
          key_nxt   = in_ch.key_tag[KEY_BITS-1:0];
          exp_nxt   = now_r + TW'(in_ch.timeout_secs);
          rcnt_nxt  = '0;
          i_nxt     = '0;
          w_nxt     = '0;
          case (in_ch.cmd)
            stq_pkg::CMD_ADD: begin
              i_nxt = cnt_r;
              if (cnt_r == CW'(DEPTH)) begin
                rkind_nxt = stq_pkg::KIND_FULL;
                state_nxt = ST_RESP;
              end else begin
                rkind_nxt = stq_pkg::KIND_ADDED;
                state_nxt = ST_ADD_RD;
              end
            end
            stq_pkg::CMD_TICK: begin
              now_nxt   = now_r + 1'b1;
              rkind_nxt = stq_pkg::KIND_DONE;
              state_nxt = ST_TK_RD;
            end
            default: begin
              rkind_nxt = stq_pkg::KIND_DELETED;
              state_nxt = ST_RUN;
            end
          endcase
        end
      end

      ST_ADD_RD: begin
        raddr = i_r - 1'b1;
        if (i_r == '0) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = {exp_r, own_r, key_r};
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_ADD_WR;
        end
      end

      ST_ADD_WR: begin
        we    = 1'b1;
        waddr = i_r;
        if (rd_exp > exp_r) begin
          // shift the later entry up one place
          i_nxt     = i_r - 1'b1;
          state_nxt = ST_ADD_RD;
        end else begin
          wdata     = {exp_r, own_r, key_r};
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_RESP;
        end
      end

      ST_RUN: begin
        // stream entries i..cnt-1 down to w, dropping matches
        if (i_r < cnt_r) begin
          i_nxt  = i_r + 1'b1;
          pv_nxt = 1'b1;
        end
        if (pv_r && !hit) begin
          we    = 1'b1;
          w_nxt = w_r + 1'b1;
        end
        if (!pv_r && (i_r == cnt_r)) begin
          cnt_nxt   = w_r;
          if (cmd_r != stq_pkg::CMD_TICK) begin
            rcnt_nxt = stq_pkg::RCNT_W'(cnt_r - w_r);
          end
          state_nxt = ST_RESP;
        end
      end

      ST_TK_RD: begin
        if (i_r == cnt_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_TK_CHK;
        end
      end

      ST_TK_CHK: begin
        if (rd_exp <= now_r) begin
          if (slot_free) begin
            ov_nxt    = 1'b1;
            okind_nxt = stq_pkg::KIND_EXPIRED;
            oown_nxt  = rd_own;
            okey_nxt  = stq_pkg::KEY_W'(rd_key);
            orcnt_nxt = '0;
            olast_nxt = 1'b0;
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_TK_RD;
          end
        end else begin
          // close up the survivors from index i
          w_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = rkind_r;
          oown_nxt  = '0;
          okey_nxt  = '0;
          orcnt_nxt = rcnt_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold control state; payload registers need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      now_r   <= '0;
      ov_r    <= 1'b0;
      pv_r    <= 1'b0;
      i_r     <= '0;
      w_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      now_r   <= now_nxt;
      ov_r    <= ov_nxt;
      pv_r    <= pv_nxt;
      i_r     <= i_nxt;
      w_r     <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    own_r   <= own_nxt;
    key_r   <= key_nxt;
    exp_r   <= exp_nxt;
    rkind_r <= rkind_nxt;
    rcnt_r  <= rcnt_nxt;
    okind_r <= okind_nxt;
    oown_r  <= oown_nxt;
    okey_r  <= okey_nxt;
    orcnt_r <= orcnt_nxt;
    olast_r <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> w_r <= i_r)
    else $error("write pointer passed read pointer");

  a_tick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TK_CHK |-> i_r < cnt_r)
    else $error("expiry check beyond stored entries");
`endif

endmodule
